// ----- sv/hnpq_pkg.sv -----
// Shared constants, types and helper functions of the held-note period quantizer.
`default_nettype none

package hnpq_pkg;

    // Field widths of the stream items.
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int PERIOD_W  = 23;
    localparam int ACTION_W  = 2;

    // Table and pitch-class storage.
    localparam int NOTE_COUNT  = 128;
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CLASS_COUNT = 12;
    localparam int PC_W        = $clog2(CLASS_COUNT);
    localparam int COUNT_W     = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Number of table entries examined by one query.
    localparam int SCAN_LEN = (NOTE_COUNT < TABLE_DEPTH) ? NOTE_COUNT : TABLE_DEPTH;
    localparam int SCAN_W   = $clog2(SCAN_LEN + 1);

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = NOTE_W + VEL_W + PERIOD_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = PERIOD_W + NOTE_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // Reciprocal of twelve for seven-bit notes: floor(n * 43 / 512) == floor(n / 12).
    localparam int RECIP_MUL   = 43;
    localparam int RECIP_SHIFT = 9;
    localparam int PROD_W      = NOTE_W + 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2,
        ACT_QUERY    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Command to the held-note counters.
    typedef struct packed {
        logic              valid;
        logic              press;
        logic [NOTE_W-1:0] note;
    } hold_cmd_t;

    // Pitch class of a note, using a multiply by the reciprocal of twelve.
    function automatic logic [PC_W-1:0] pitch_class(input logic [NOTE_W-1:0] note);
        logic [PROD_W-1:0] prod;
        logic [PC_W-1:0]   quo;
        logic [NOTE_W-1:0] base;
        prod = PROD_W'(note) * PROD_W'(RECIP_MUL);
        quo  = prod[RECIP_SHIFT +: PC_W];
        base = NOTE_W'(NOTE_W'(quo) * NOTE_W'(CLASS_COUNT));
        return PC_W'(note - base);
    endfunction

endpackage

`default_nettype wire

// ----- sv/hnpq_table.sv -----
// Period table memory with one write port and one registered read port.
`default_nettype none

module hnpq_table
    import hnpq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire logic [PERIOD_W-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output      logic [PERIOD_W-1:0] rd_data
);

    logic [PERIOD_W-1:0] period_mem [TABLE_DEPTH];
    logic [PERIOD_W-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            period_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= period_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/hnpq_hold.sv -----
// Saturating held-note counters, one for each pitch class.
`default_nettype none

module hnpq_hold
    import hnpq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hold_cmd_t       cmd,
    input  wire logic [PC_W-1:0] rd_pc,
    output      logic            held
);

    logic [COUNT_W-1:0] cnt_reg [CLASS_COUNT];
    logic [PC_W-1:0]    wr_pc;
    logic [COUNT_W-1:0] cur_cnt;
    logic [COUNT_W-1:0] cnt_next;
    logic               wr_ok;

    // Pitch class of the commanded note and its present count.
    always_comb
    begin
        wr_pc   = pitch_class(cmd.note);
        wr_ok   = (32'(wr_pc) < CLASS_COUNT);
        cur_cnt = wr_ok ? cnt_reg[wr_pc] : '0;
        cnt_next = cur_cnt;
        if (cmd.press)
        begin
            if (cur_cnt != COUNT_MAX)
            begin
                cnt_next = cur_cnt + COUNT_W'(1);
            end
        end
        else
        begin
            if (cur_cnt != '0)
            begin
                cnt_next = cur_cnt - COUNT_W'(1);
            end
        end
    end

    // Counter update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.valid && wr_ok)
        begin
            cnt_reg[wr_pc] <= cnt_next;
        end
    end

    // A class is held while its count is not zero.
    assign held = (32'(rd_pc) < CLASS_COUNT) ? (cnt_reg[rd_pc] != '0) : 1'b0;

endmodule

`default_nettype wire

// ----- sv/held_note_period_quantizer_top.sv -----
// Top level of the held-note period quantizer: stream ports, scan sequencer and compare unit.
//
// Load, note-on and note-off beats are taken while the block is idle, and the block stays
// ready for the next beat. A query beat starts a scan of the period table through its single
// read port, one entry per cycle, with one shared subtract-and-compare unit working on each
// entry in the cycle after its read; once the scan ends and the output register is free, the
// result is placed there and the block is ready for its next beat again. The output register
// lets the next beat be accepted while a result still waits to be taken. Note 0 is always the
// starting choice, ties keep the lower note, and beyond it only entries whose pitch class is
// held take part.
`default_nettype none

module held_note_period_quantizer_top
    import hnpq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // Bits from low: note[6:0], velocity[13:7], period[36:14], zero fill.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // Bits from low: action[1:0].
    input  wire logic [ACTION_W-1:0]  s_axis_tuser,
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Bits from low: nearest_period[22:0], nearest_note[29:23], zero fill.
    output      logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Unpacked input fields.
    action_t             action;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    velocity;
    logic [PERIOD_W-1:0] period;

    assign action   = action_t'(s_axis_tuser);
    assign note     = s_axis_tdata[NOTE_W-1:0];
    assign velocity = s_axis_tdata[NOTE_W +: VEL_W];
    assign period   = s_axis_tdata[NOTE_W + VEL_W +: PERIOD_W];

    // Sequencer and scan registers.
    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   issue_reg, issue_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                cmp_first_reg, cmp_first_next;
    logic                cmp_held_reg, cmp_held_next;
    logic [NOTE_W-1:0]   cmp_note_reg, cmp_note_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers.
    logic [PERIOD_W-1:0] query_reg;
    logic [PERIOD_W-1:0] best_diff_reg;
    logic [PERIOD_W-1:0] best_period_reg;
    logic [NOTE_W-1:0]   best_note_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic [NOTE_W-1:0]   out_note_reg;

    logic                in_beat;
    logic                rd_en;
    logic                out_load;
    logic                held;
    logic                tbl_wr_en;
    logic [PERIOD_W-1:0] rd_data;
    hold_cmd_t           hold_cmd;

    // Compare unit signals.
    logic [PERIOD_W-1:0] cand_diff;
    logic                take;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // Table writes and counter commands come straight from accepted beats.
    assign tbl_wr_en = in_beat && (action == ACT_LOAD)
                       && ((NOTE_W + 1)'(note) < (NOTE_W + 1)'(NOTE_COUNT));

    always_comb
    begin
        hold_cmd.valid = in_beat && ((action == ACT_NOTE_ON) || (action == ACT_NOTE_OFF));
        hold_cmd.press = (action == ACT_NOTE_ON) && (velocity != '0);
        hold_cmd.note  = note;
    end

    hnpq_table u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (note[ADDR_W-1:0]),
        .wr_data (period),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    hnpq_hold u_hold (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hold_cmd),
        .rd_pc (pc_reg),
        .held  (held)
    );

    // Shared distance and compare unit.
    always_comb
    begin
        cand_diff = (query_reg >= rd_data) ? (query_reg - rd_data) : (rd_data - query_reg);
        take = cmp_valid_reg && (cmp_first_reg || (cmp_held_reg && (cand_diff < best_diff_reg)));
    end

    // Next state and sequencer outputs.
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        pc_next        = pc_reg;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        s_axis_tready  = 1'b0;
        cmp_valid_next = 1'b0;
        cmp_first_next = (issue_reg == '0);
        cmp_held_next  = held;
        cmp_note_next  = issue_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_beat && (action == ACT_QUERY))
                begin
                    issue_next = '0;
                    pc_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < SCAN_W'(SCAN_LEN))
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + SCAN_W'(1);
                    pc_next        = (pc_reg == PC_W'(CLASS_COUNT - 1)) ? '0
                                                                       : pc_reg + PC_W'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: filled at the end of a scan, emptied when the beat is taken.
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            pc_reg        <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_first_reg <= 1'b0;
            cmp_held_reg  <= 1'b0;
            cmp_note_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pc_reg        <= pc_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_first_reg <= cmp_first_next;
            cmp_held_reg  <= cmp_held_next;
            cmp_note_reg  <= cmp_note_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Query value, running best choice and result payload.
    always_ff @(posedge clk)
    begin
        if (in_beat && (action == ACT_QUERY))
        begin
            query_reg <= period;
        end
        if (take)
        begin
            best_diff_reg   <= cand_diff;
            best_period_reg <= rd_data;
            best_note_reg   <= cmp_note_reg;
        end
        if (out_load)
        begin
            out_period_reg <= best_period_reg;
            out_note_reg   <= best_note_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - M_DATA_BITS)'(0), out_note_reg, out_period_reg};

endmodule

`default_nettype wire
